@@ rtl/pttt_pkg.sv @@
// Shared types and constants for the periodic task timer table.
// Used by pttt_mem, pttt_seq and periodic_task_timer_table; no dependencies.
`timescale 1ns / 1ps

package pttt_pkg;

    // Number of table entries and the cap on firings reported per tick.
    localparam int NUM_TASKS   = 8;
    localparam int MAX_RESULTS = 8;

    // Entry index and firing counter widths.
    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // Field widths of one input item and one result item.
    localparam int CMD_W    = 3;
    localparam int TIDX_W   = 4;
    localparam int TIME_W   = 32;
    localparam int KEEP_W   = 8;
    localparam int TASKID_W = 3;

    // Stream packing: tdata rounded up to whole bytes.
    localparam int S_TDATA_RAW = TIDX_W + TIME_W + TIME_W + KEEP_W;
    localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((TASKID_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd4;

    // One memory word: reload period and next deadline.
    typedef struct packed {
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] deadline;
    } t_entry;

    // Access request from the sequencer to the entry memory.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_req;

    // One result item.
    typedef struct packed {
        logic                fired;
        logic [TASKID_W-1:0] task_id;
        logic                last;
        logic                error;
    } t_res;

endpackage

@@ rtl/periodic_task_timer_table.sv @@
// Top level of the periodic task timer table: stream ports, output register,
// sequencer and entry memory; depends on pttt_pkg, pttt_mem and pttt_seq.
`timescale 1ns / 1ps

// The block keeps a table of NUM_TASKS periodic timers. Each entry has an
// enable flag and a suspend mark, held in flip-flops, and a reload period and
// deadline, held in a synchronous memory with a registered read. Set, clear,
// suspend and resume act on one entry; a task index equal to NUM_TASKS with
// suspend or resume acts on all entries, where suspend-all remembers which
// entries were enabled and resume-all re-enables exactly those. A tick walks
// the memory in index order, one entry per cycle unless the output stalls:
// the read of the next entry overlaps the deadline compare and write-back
// of the current one. Every enabled entry whose deadline is at or below now
// fires, gets now plus its period as its new deadline, and stays enabled only
// if its keep bit is set. Each firing gives one result item in index order
// with tlast on the final one; a tick with no firing gives one empty item
// with tlast. Every other command gives one item carrying the error flag for
// an index out of range. Timing: one item is worked on at a time. A command
// other than a tick goes from idle to the response state, which hands its
// result to the output register once that can take it, and then back to
// idle, where the next item can be accepted. A tick goes from idle through
// the walk state, which steps through the entries over the single memory
// read port, and the final state, which hands over the last result, back to
// idle; the output side can stall the walk and the final state. The next
// item is accepted while the last result still waits in the output register.
// No clearing pass follows reset: per-entry valid bits make unwritten entries
// read as zero.

module periodic_task_timer_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // task_index [3:0], period [35:4], now [67:36], keep_mask [75:68]
    input  logic [pttt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // command [2:0]
    input  logic [pttt_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // task_id [2:0]
    output logic [pttt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // fired [0], error [1]
    output logic [pttt_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast
);
    import pttt_pkg::*;

    localparam int PER_LO  = TIDX_W;
    localparam int NOW_LO  = PER_LO + TIME_W;
    localparam int KEEP_LO = NOW_LO + TIME_W;

    t_mem_req mem_req;
    t_entry   rd_data;
    logic     out_free;
    logic     res_valid;
    t_res     res;

    logic r_out_vld;
    t_res r_out;

    // Output register: it takes a new result when empty or being emptied.
    assign out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    pttt_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_command    (s_axis_tuser),
        .i_task_index (s_axis_tdata[TIDX_W-1:0]),
        .i_period     (s_axis_tdata[PER_LO +: TIME_W]),
        .i_now        (s_axis_tdata[NOW_LO +: TIME_W]),
        .i_keep_mask  (s_axis_tdata[KEEP_LO +: KEEP_W]),
        .o_mem_req    (mem_req),
        .i_rd_data    (rd_data),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    pttt_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_TDATA_W'(r_out.task_id);
    assign m_axis_tuser  = {r_out.error, r_out.fired};
    assign m_axis_tlast  = r_out.last;

    // The sequencer only hands over a result when the output register can
    // take it; otherwise a result would be overwritten.
    a_res_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> out_free)
        else $error("result produced while the output register was full");

    // Only a firing may be followed by further results of the same item.
    a_not_last_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res.last) |-> res.fired)
        else $error("non-final result without a firing");

    // An error is reported only on the single result of a non-tick command.
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res.error) |-> (res.last && !res.fired))
        else $error("error flag on a firing or non-final result");

    // After an accepted item the block is busy until its results are out.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new item accepted before the previous one finished");

    // No memory write may coincide with a read of the same entry.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
        else $error("memory read and write to the same entry in one cycle");

endmodule

@@ rtl/pttt_mem.sv @@
// Entry memory of the periodic task timer table: period and deadline per task.
// One write and one registered read per cycle; depends on pttt_pkg.
`timescale 1ns / 1ps

module pttt_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pttt_pkg::t_mem_req i_req,
    output pttt_pkg::t_entry   o_rd_data
);
    import pttt_pkg::*;

    t_entry               r_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_vld;
    t_entry               r_rd_data;
    logic                 r_rd_vld;

    // Written entries are tracked so that an entry never written reads as zero,
    // matching the cleared table after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_vld  <= r_vld[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ rtl/pttt_seq.sv @@
// Command sequencer of the periodic task timer table: enable and suspend flags,
// command decode and the tick walk over the entry memory; depends on pttt_pkg.
`timescale 1ns / 1ps

module pttt_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pttt_pkg::CMD_W-1:0]     i_command,
    input  logic [pttt_pkg::TIDX_W-1:0]    i_task_index,
    input  logic [pttt_pkg::TIME_W-1:0]    i_period,
    input  logic [pttt_pkg::TIME_W-1:0]    i_now,
    input  logic [pttt_pkg::KEEP_W-1:0]    i_keep_mask,
    output pttt_pkg::t_mem_req             o_mem_req,
    input  pttt_pkg::t_entry               i_rd_data,
    input  logic                           i_out_free,
    output logic                           o_res_valid,
    output pttt_pkg::t_res                 o_res
);
    import pttt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]           r_state,    n_state;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic [TIME_W-1:0]    r_now,      n_now;
    logic [NUM_TASKS-1:0] r_keep,     n_keep;
    logic [NUM_TASKS-1:0] r_en,       n_en;
    logic [NUM_TASKS-1:0] r_mark,     n_mark;
    logic                 r_pend_vld, n_pend_vld;
    logic [IDX_W-1:0]     r_pend_id,  n_pend_id;
    logic [CNT_W-1:0]     r_cnt,      n_cnt;
    logic                 r_err,      n_err;

    logic [IDX_W-1:0]  in_idx;
    logic              idx_in_table;
    logic              idx_is_all;
    logic              fire;
    logic              report;
    logic              blocked;
    logic [TIME_W-1:0] reload;

    assign in_idx       = IDX_W'(i_task_index);
    assign idx_in_table = (32'(i_task_index) < 32'(NUM_TASKS));
    assign idx_is_all   = (32'(i_task_index) == 32'(NUM_TASKS));

    // Walk step: the registered read data belongs to entry r_idx.
    assign fire    = r_en[r_idx] && !(i_rd_data.deadline > r_now);
    assign report  = fire && (32'(r_cnt) < 32'(MAX_RESULTS));
    assign blocked = report && r_pend_vld && !i_out_free;
    assign reload  = r_now + i_rd_data.interval;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_now      = r_now;
        n_keep     = r_keep;
        n_en       = r_en;
        n_mark     = r_mark;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        n_cnt      = r_cnt;
        n_err      = r_err;
        o_ready    = 1'b0;
        o_mem_req  = '0;
        o_res_valid = 1'b0;
        o_res      = '0;

        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_err   = 1'b0;
                    n_state = ST_RESP;
                    case (i_command)
                        CMD_TICK: begin
                            n_now             = i_now;
                            n_keep            = NUM_TASKS'(i_keep_mask);
                            n_idx             = '0;
                            n_pend_vld        = 1'b0;
                            n_cnt             = '0;
                            o_mem_req.rd_en   = 1'b1;
                            o_mem_req.rd_addr = '0;
                            n_state           = ST_WALK;
                        end
                        CMD_SET: begin
                            if (!idx_in_table) begin
                                n_err = 1'b1;
                            end else begin
                                n_en[in_idx]               = 1'b1;
                                o_mem_req.wr_en            = 1'b1;
                                o_mem_req.wr_addr          = in_idx;
                                o_mem_req.wr_data.interval = i_period;
                                o_mem_req.wr_data.deadline = i_now + i_period;
                            end
                        end
                        CMD_CLEAR: begin
                            if (!idx_in_table) begin
                                n_err = 1'b1;
                            end else begin
                                n_en[in_idx] = 1'b0;
                            end
                        end
                        CMD_SUSPEND: begin
                            if (idx_is_all) begin
                                n_mark = r_mark | r_en;
                                n_en   = '0;
                            end else if (idx_in_table) begin
                                n_en[in_idx] = 1'b0;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        CMD_RESUME: begin
                            if (idx_is_all) begin
                                n_en   = r_en | r_mark;
                                n_mark = '0;
                            end else if (idx_in_table) begin
                                n_en[in_idx] = 1'b1;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        default: begin
                            n_err = 1'b0;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (!blocked) begin
                    if (fire) begin
                        n_en[r_idx]                = r_keep[r_idx];
                        o_mem_req.wr_en            = 1'b1;
                        o_mem_req.wr_addr          = r_idx;
                        o_mem_req.wr_data.interval = i_rd_data.interval;
                        o_mem_req.wr_data.deadline = reload;
                    end
                    // A firing is held back until the next one (or the end of the walk),
                    // since only that tells whether it is the last.
                    if (report) begin
                        if (r_pend_vld) begin
                            o_res_valid   = 1'b1;
                            o_res.fired   = 1'b1;
                            o_res.task_id = TASKID_W'(r_pend_id);
                        end
                        n_pend_vld = 1'b1;
                        n_pend_id  = r_idx;
                        n_cnt      = CNT_W'(r_cnt + 1'b1);
                    end
                    if (r_idx == IDX_W'(NUM_TASKS - 1)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_idx             = IDX_W'(r_idx + 1'b1);
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = IDX_W'(r_idx + 1'b1);
                    end
                end
            end

            ST_FIN: begin
                if (i_out_free) begin
                    o_res_valid   = 1'b1;
                    o_res.fired   = r_pend_vld;
                    o_res.task_id = r_pend_vld ? TASKID_W'(r_pend_id) : '0;
                    o_res.last    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end

            ST_RESP: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    o_res.last  = 1'b1;
                    o_res.error = r_err;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_en       <= '0;
            r_mark     <= '0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_en       <= n_en;
            r_mark     <= n_mark;
            r_pend_vld <= n_pend_vld;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_keep    <= n_keep;
        r_pend_id <= n_pend_id;
        r_err     <= n_err;
    end

endmodule
